### rtl/core/lrn_pkg.sv
// Shared types and constants for the local response normalization block.
// No dependencies.
package lrn_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SUM_RD,
    S_SUM_ACC,
    S_BASE,
    S_NORM,
    S_LOG,
    S_EMUL,
    S_EXP,
    S_PMUL,
    S_ROUND,
    S_OUT
  } lrn_state_e;

  typedef enum logic [1:0] {
    REG_SCALE    = 2'd0,
    REG_BIAS     = 2'd1,
    REG_EXPONENT = 2'd2,
    REG_WINDOW   = 2'd3
  } lrn_reg_e;

  localparam logic [31:0] SCALE_RST    = 32'd429497;
  localparam logic [31:0] BIAS_RST     = 32'd65536;
  localparam logic [15:0] EXPONENT_RST = 16'd12288;
  localparam logic [4:0]  WINDOW_RST   = 5'd1;

  localparam logic [35:0] SUM_MAX = 36'hF_FFFF_FFFF;
  localparam logic [30:0] Q30     = 31'h4000_0000;

  typedef logic [30:0] root_tab_t [16];

  // 2^(2^-i) in Q1.30, i = 1..16, each the integer square root of the one before
  function automatic root_tab_t exp2_roots();
    root_tab_t   t;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bv;
    r = 64'h8000_0000;
    for (int i = 0; i < 16; i++) begin
      v   = r << 30;
      res = 64'd0;
      bv  = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (v >= res + bv) begin
          v   = v - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      r    = res;
      t[i] = r[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t EXP2_ROOTS = exp2_roots();

endpackage

### rtl/core/lrn_window.sv
// Channel sample store: a shift line, newest sample at entry 0, one read port.
// Depends on nothing but its parameters.
module lrn_window #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int IW          = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [IW-1:0]          rd_idx_i,
  output logic [SAMPLE_BITS-1:0] rd_data_o
);

  logic [SAMPLE_BITS-1:0] mem_q [MAX_WINDOW];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      mem_q[0] <= sample_i;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        mem_q[i] <= mem_q[i-1];
      end
    end
  end

  always_comb begin
    rd_data_o = mem_q[0];
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (rd_idx_i == IW'(i)) begin
        rd_data_o = mem_q[i];
      end
    end
  end

endmodule

### rtl/core/local_response_norm.sv
// Local response normalization: for each result of an accepted item the block sums the
// window squares, runs a leading-one search, then log2, exp2, product and rounding.
// Multiplies go through one shared 32x32 multiplier (log2 by 16 squarings, exp2 by 16
// root products), but not scale times the top sum bits. Input is held off until the
// emit check after the last result finds no more; an item with no result holds it too.
// Reset (rst_ni low, asynchronous) clears counters and the sequencer and loads the
// register defaults; the sample store is left unset.
module local_response_norm #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   last_channel_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] result_o,
  output logic                   last_of_position_o,
  output logic                   saturated_o
);

  localparam int IW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int MAX_OUT = MAX_WINDOW / 2 + 1;
  localparam int NW      = $clog2(MAX_OUT + 1);
  localparam int SB      = SAMPLE_BITS;

  // configuration
  logic [31:0] scale_q, bias_q;
  logic [15:0] exponent_q;
  logic [4:0]  window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= lrn_pkg::SCALE_RST;
      bias_q     <= lrn_pkg::BIAS_RST;
      exponent_q <= lrn_pkg::EXPONENT_RST;
      window_q   <= lrn_pkg::WINDOW_RST;
    end else if (cfg_we_i) begin
      case (lrn_pkg::lrn_reg_e'(cfg_index_i))
        lrn_pkg::REG_SCALE:    scale_q    <= cfg_data_i;
        lrn_pkg::REG_BIAS:     bias_q     <= cfg_data_i;
        lrn_pkg::REG_EXPONENT: exponent_q <= cfg_data_i[15:0];
        lrn_pkg::REG_WINDOW:   window_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  lrn_pkg::lrn_state_e state_q, state_d;
  logic [15:0] cc_q, cc_d, ec_q, ec_d;
  logic [NW-1:0] n_q, n_d;
  logic        last_q, last_d;
  logic [15:0] ov_q, ov_d;
  logic [16:0] off_q, off_d, end_q, end_d;
  logic        sqv_q, sqv_d;
  logic [35:0] sum_q, sum_d;
  logic [SB-1:0] center_q, center_d;
  logic [37:0] norm_q, norm_d;
  logic signed [6:0] p_q, p_d;
  logic [15:0] frac_q, frac_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        lgneg_q, lgneg_d;
  logic signed [9:0] k_q, k_d;
  logic [15:0] f_q, f_d;
  logic [30:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] opa_q, opa_d, opb_q, opb_d;
  logic [SB-1:0] res_q, res_d;
  logic        rsat_q, rsat_d, rlast_q, rlast_d;
  logic        ov_valid_q, ov_valid_d;
  logic [SB-1:0] out_res_q, out_res_d;
  logic        out_last_q, out_last_d, out_sat_q, out_sat_d;

  logic [63:0] mul;
  assign mul = 64'(opa_q) * 64'(opb_q);

  logic          accept;
  logic [IW-1:0] rd_idx;
  logic [SB-1:0] rd_data;

  assign accept = in_valid_i && !in_stall_o;

  lrn_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .IW         (IW)
  ) u_window (
    .clk_i    (clk_i),
    .shift_i  (accept),
    .sample_i (sample_i),
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_data)
  );

  function automatic logic [SB-1:0] mag_of(logic [SB-1:0] raw);
    return raw[SB-1] ? (~raw + SB'(1)) : raw;
  endfunction

  logic [5:0]  size;
  logic [15:0] lo, hi, pend, down;
  logic [37:0] base;
  logic [35:0] sq_sat;
  logic [36:0] sum_w;
  logic [31:0] sq;
  logic [30:0] m_new;
  logic [15:0] frac_new;
  logic signed [23:0] lg;
  logic [23:0] lg_abs;
  logic signed [39:0] e30;
  logic [30:0] acc_new;
  logic [63:0] lim, mres, half;
  logic [95:0] wide;
  logic signed [10:0] s_r;
  logic signed [10:0] sh_l;
  logic        sat_r;

  always_comb begin
    size = {1'b0, window_q};
    if (size == 6'd0) size = 6'd1;
    if (size > 6'(MAX_WINDOW)) size = 6'(MAX_WINDOW);
    lo   = 16'((size - 6'd1) >> 1);
    hi   = 16'(size >> 1);
    pend = cc_q - ec_q;
    down = (lo < ec_q) ? lo : ec_q;
  end

  always_comb begin
    state_d    = state_q;
    cc_d       = cc_q;
    ec_d       = ec_q;
    n_d        = n_q;
    last_d     = last_q;
    ov_d       = ov_q;
    off_d      = off_q;
    end_d      = end_q;
    sqv_d      = sqv_q;
    sum_d      = sum_q;
    center_d   = center_q;
    norm_d     = norm_q;
    p_d        = p_q;
    frac_d     = frac_q;
    cnt_d      = cnt_q;
    lgneg_d    = lgneg_q;
    k_d        = k_q;
    f_d        = f_q;
    acc_d      = acc_q;
    prod_d     = prod_q;
    opa_d      = opa_q;
    opb_d      = opb_q;
    res_d      = res_q;
    rsat_d     = rsat_q;
    rlast_d    = rlast_q;
    ov_valid_d = ov_valid_q;
    out_res_d  = out_res_q;
    out_last_d = out_last_q;
    out_sat_d  = out_sat_q;
    rd_idx     = off_q[IW-1:0];
    base       = '0;
    sq_sat     = '0;
    sum_w      = '0;
    sq         = '0;
    m_new      = '0;
    frac_new   = '0;
    lg         = '0;
    lg_abs     = '0;
    e30        = '0;
    acc_new    = '0;
    lim        = '0;
    mres       = '0;
    half       = '0;
    wide       = '0;
    s_r        = '0;
    sh_l       = '0;
    sat_r      = 1'b0;

    if (ov_valid_q && !out_stall_i) ov_valid_d = 1'b0;

    case (state_q)
      lrn_pkg::S_IDLE: begin
        if (accept) begin
          cc_d    = cc_q + 16'd1;
          last_d  = last_channel_i;
          n_d     = '0;
          state_d = lrn_pkg::S_CHECK;
        end
      end
      lrn_pkg::S_CHECK: begin
        if ((last_q ? (pend != 16'd0) : (pend > hi)) && (n_q < NW'(MAX_OUT))) begin
          ov_d    = pend - 16'd1;
          sum_d   = '0;
          state_d = lrn_pkg::S_SUM_RD;
          off_d   = {1'b0, (pend - 16'd1)} - {1'b0, ((hi < (pend - 16'd1)) ? hi
                                                      : (pend - 16'd1))};
          end_d   = {1'b0, (pend - 16'd1)} + {1'b0, down};
        end else begin
          if (last_q) begin
            cc_d = '0;
            ec_d = '0;
          end
          state_d = lrn_pkg::S_IDLE;
        end
      end
      lrn_pkg::S_SUM_RD: begin
        if (off_q > end_q) begin
          rd_idx   = ov_q[IW-1:0];
          center_d = (ov_q < 16'(MAX_WINDOW)) ? rd_data : '0;
          opa_d    = scale_q;
          opb_d    = sum_q[31:0];
          state_d  = lrn_pkg::S_BASE;
        end else begin
          sqv_d   = off_q < 17'(MAX_WINDOW);
          opa_d   = 32'(mag_of(rd_data));
          opb_d   = 32'(mag_of(rd_data));
          state_d = lrn_pkg::S_SUM_ACC;
        end
      end
      lrn_pkg::S_SUM_ACC: begin
        if (sqv_q) begin
          sq_sat = (mul > 64'(lrn_pkg::SUM_MAX)) ? lrn_pkg::SUM_MAX : mul[35:0];
          sum_w  = {1'b0, sum_q} + {1'b0, sq_sat};
          sum_d  = sum_w[36] ? lrn_pkg::SUM_MAX : sum_w[35:0];
        end
        off_d   = off_q + 17'd1;
        state_d = lrn_pkg::S_SUM_RD;
      end
      lrn_pkg::S_BASE: begin
        base = 38'(bias_q) + 38'(scale_q) * 38'(sum_q[35:32]) + 38'(mul[63:32]);
        if (base == '0) base = 38'd1;
        norm_d  = base;
        p_d     = 7'sd37;
        state_d = lrn_pkg::S_NORM;
      end
      lrn_pkg::S_NORM: begin
        if (norm_q[37]) begin
          opa_d   = {1'b0, norm_q[37:7]};
          opb_d   = {1'b0, norm_q[37:7]};
          frac_d  = '0;
          cnt_d   = '0;
          state_d = lrn_pkg::S_LOG;
        end else if (norm_q[37:30] == 8'd0) begin
          norm_d = norm_q << 8;
          p_d    = p_q - 7'sd8;
        end else begin
          norm_d = norm_q << 1;
          p_d    = p_q - 7'sd1;
        end
      end
      lrn_pkg::S_LOG: begin
        sq       = mul[61:30];
        m_new    = sq[31] ? sq[31:1] : sq[30:0];
        frac_new = {frac_q[14:0], sq[31]};
        frac_d   = frac_new;
        opa_d    = {1'b0, m_new};
        opb_d    = {1'b0, m_new};
        cnt_d    = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          lg      = ($signed(24'(p_q)) - 24'sd16) * 24'sd65536 + $signed({8'd0, frac_new});
          lgneg_d = lg[23];
          lg_abs  = lg[23] ? 24'(-lg) : 24'(lg);
          opa_d   = 32'(exponent_q);
          opb_d   = 32'(lg_abs);
          state_d = lrn_pkg::S_EMUL;
        end
      end
      lrn_pkg::S_EMUL: begin
        e30     = lgneg_q ? $signed(mul[39:0]) : -$signed(mul[39:0]);
        k_d     = e30[39:30];
        f_d     = e30[29:14];
        acc_d   = lrn_pkg::Q30;
        opa_d   = 32'(lrn_pkg::Q30);
        opb_d   = 32'(lrn_pkg::EXP2_ROOTS[0]);
        cnt_d   = '0;
        state_d = lrn_pkg::S_EXP;
      end
      lrn_pkg::S_EXP: begin
        acc_new = f_q[~cnt_q] ? mul[60:30] : acc_q;
        acc_d   = acc_new;
        opa_d   = {1'b0, acc_new};
        opb_d   = 32'(lrn_pkg::EXP2_ROOTS[cnt_q + 4'd1]);
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          opa_d   = 32'(mag_of(center_q));
          opb_d   = {1'b0, acc_new};
          state_d = lrn_pkg::S_PMUL;
        end
      end
      lrn_pkg::S_PMUL: begin
        prod_d  = mul;
        state_d = lrn_pkg::S_ROUND;
      end
      lrn_pkg::S_ROUND: begin
        lim = 64'd1 << (SB - 1);
        if (!center_q[SB-1]) lim = lim - 64'd1;
        if (k_q >= 10'sd30) begin
          sh_l = 11'(k_q) - 11'sd30;
          if (prod_q == '0) begin
            mres = '0;
          end else if (sh_l >= 11'sd32) begin
            sat_r = 1'b1;
          end else begin
            wide  = {32'd0, prod_q} << sh_l[4:0];
            sat_r = wide > 96'(lim);
            mres  = wide[63:0];
          end
        end else begin
          s_r = 11'sd30 - 11'(k_q);
          if (s_r >= 11'sd63) begin
            mres = '0;
          end else begin
            half = 64'd1 << (s_r[5:0] - 6'd1);
            mres = (prod_q + half) >> s_r[5:0];
          end
        end
        if (sat_r || mres > lim) begin
          mres  = lim;
          sat_r = 1'b1;
        end
        res_d   = center_q[SB-1] ? (SB'(0) - mres[SB-1:0]) : mres[SB-1:0];
        rsat_d  = sat_r;
        rlast_d = last_q && (pend == 16'd1);
        state_d = lrn_pkg::S_OUT;
      end
      lrn_pkg::S_OUT: begin
        if (!ov_valid_q || !out_stall_i) begin
          ov_valid_d = 1'b1;
          out_res_d  = res_q;
          out_last_d = rlast_q;
          out_sat_d  = rsat_q;
          ec_d       = ec_q + 16'd1;
          n_d        = n_q + NW'(1);
          state_d    = lrn_pkg::S_CHECK;
        end
      end
      default: state_d = lrn_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lrn_pkg::S_IDLE;
      cc_q       <= '0;
      ec_q       <= '0;
      n_q        <= '0;
      last_q     <= 1'b0;
      ov_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cc_q       <= cc_d;
      ec_q       <= ec_d;
      n_q        <= n_d;
      last_q     <= last_d;
      ov_valid_q <= ov_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ov_q       <= ov_d;
    off_q      <= off_d;
    end_q      <= end_d;
    sqv_q      <= sqv_d;
    sum_q      <= sum_d;
    center_q   <= center_d;
    norm_q     <= norm_d;
    p_q        <= p_d;
    frac_q     <= frac_d;
    cnt_q      <= cnt_d;
    lgneg_q    <= lgneg_d;
    k_q        <= k_d;
    f_q        <= f_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    opa_q      <= opa_d;
    opb_q      <= opb_d;
    res_q      <= res_d;
    rsat_q     <= rsat_d;
    rlast_q    <= rlast_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
    out_sat_q  <= out_sat_d;
  end

  assign in_stall_o         = state_q != lrn_pkg::S_IDLE;
  assign out_valid_o        = ov_valid_q;
  assign result_o           = out_res_q;
  assign last_of_position_o = out_last_q;
  assign saturated_o        = out_sat_q;

  a_max_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_OUT))
    else $error("more results than allowed for one item");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == lrn_pkg::S_CHECK)
    else $error("accepted item did not start the emit check");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrn_pkg::S_OUT && !ov_valid_q) |=> ov_valid_q)
    else $error("finished result not loaded into free output register");

  a_idle_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lrn_pkg::S_CHECK && last_q && pend == 16'd0) |=> cc_q == 16'd0)
    else $error("position end did not clear the channel count");

endmodule

### tb/sv/local_response_norm_tb.sv
// Self-checking testbench for local_response_norm: streams positions of Q7.8 samples,
// predicts every normalized result in a scoreboard class and checks the outputs.
// Depends on lrn_pkg and the local_response_norm RTL.
module local_response_norm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] result;
    logic        last;
    logic        sat;
  } lrn_out_t;

  class lrn_scoreboard;
    logic [15:0] win[16];
    int unsigned ch_cnt, em_cnt;
    logic [31:0] scale, bias;
    logic [15:0] expo;
    logic [4:0]  wsize;
    logic [63:0] roots[16];
    lrn_out_t    pending_q[$];
    int          errors;

    function new();
      logic [63:0] r;
      r = 64'd1 << 31;
      for (int i = 0; i < 16; i++) begin
        r = int_sqrt(r << 30);
        roots[i] = r;
      end
      for (int i = 0; i < 16; i++) win[i] = '0;
      ch_cnt = 0;
      em_cnt = 0;
      scale = lrn_pkg::SCALE_RST;
      bias = lrn_pkg::BIAS_RST;
      expo = lrn_pkg::EXPONENT_RST;
      wsize = lrn_pkg::WINDOW_RST;
      errors = 0;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void set_reg(lrn_pkg::lrn_reg_e idx, logic [31:0] v);
      case (idx)
        lrn_pkg::REG_SCALE:    scale = v;
        lrn_pkg::REG_BIAS:     bias = v;
        lrn_pkg::REG_EXPONENT: expo = v[15:0];
        lrn_pkg::REG_WINDOW:   wsize = v[4:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] mag_of(logic [15:0] raw);
      return raw[15] ? (64'd65536 - {48'd0, raw}) : {48'd0, raw};
    endfunction

    function longint log2_fix(logic [63:0] base);
      int p;
      logic [63:0] m, frac;
      p = 63;
      frac = 0;
      while (!base[p]) p--;
      m = (p >= 30) ? (base >> (p - 30)) : (base << (30 - p));
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          frac[0] = 1'b1;
        end
      end
      return longint'(p - 16) * 65536 + longint'(frac);
    endfunction

    function logic [63:0] exp2_fix(logic [15:0] f);
      logic [63:0] acc;
      acc = 64'd1 << 30;
      for (int i = 1; i <= 16; i++)
        if (f[16-i]) acc = (acc * roots[i-1]) >> 30;
      return acc;
    endfunction

    function lrn_out_t normalize(logic [15:0] raw, logic [63:0] sum);
      lrn_out_t o;
      logic [63:0] mag, base, acc, p, m, lim;
      longint lg, e30, e16, k, s, u, kk;
      logic [15:0] f;
      logic neg, sat;
      mag = mag_of(raw);
      neg = raw[15];
      sat = 0;
      m = 0;
      base = {32'd0, bias} + {32'd0, scale} * (sum >> 32)
           + (({32'd0, scale} * {32'd0, sum[31:0]}) >> 32);
      if (base == 0) base = 1;
      lg = log2_fix(base);
      e30 = -longint'({48'd0, expo}) * lg;
      if (e30 >= 0) e16 = e30 >>> 14;
      else e16 = -((-e30 + 16383) >>> 14);
      if (e16 >= 0) begin
        k = e16 >>> 16;
        f = e16[15:0];
      end else begin
        u = -e16;
        kk = (u + 65535) >>> 16;
        k = -kk;
        f = 16'((kk << 16) - u);
      end
      acc = exp2_fix(f);
      p = mag * acc;
      if (k <= 30) begin
        s = 30 - k;
        if (s == 0) m = p;
        else if (s >= 63) m = 0;
        else m = (p + (64'd1 << (s - 1))) >> s;
      end else if (p != 0) begin
        s = k - 30;
        if (s >= 63 || p > ({64{1'b1}} >> s)) sat = 1;
        else m = p << s;
      end
      lim = neg ? 64'd32768 : 64'd32767;
      if (sat || m > lim) begin
        m = lim;
        sat = 1;
      end
      o.result = neg ? 16'(-m) : m[15:0];
      o.sat = sat;
      o.last = 0;
      return o;
    endfunction

    function lrn_out_t window_result(int unsigned pend, int unsigned lo, int unsigned hi,
                                     bit last);
      int unsigned ov, up, down;
      logic [63:0] sum, sq;
      logic [15:0] center;
      lrn_out_t o;
      ov = pend - 1;
      up = (hi < ov) ? hi : ov;
      down = (lo < em_cnt) ? lo : em_cnt;
      sum = 0;
      for (int unsigned off = ov - up; off <= ov + down; off++) begin
        if (off >= 16) continue;
        sq = mag_of(win[off]) * mag_of(win[off]);
        sum += sq;
        if (sum > lrn_pkg::SUM_MAX) sum = lrn_pkg::SUM_MAX;
      end
      center = (ov < 16) ? win[ov] : 16'd0;
      o = normalize(center, sum);
      o.last = last && pend == 1;
      return o;
    endfunction

    function void note_input(logic [15:0] smp, bit last);
      int unsigned size, lo, hi, pend, n;
      size = wsize;
      if (size == 0) size = 1;
      if (size > 16) size = 16;
      lo = (size - 1) / 2;
      hi = size / 2;
      for (int i = 15; i > 0; i--) win[i] = win[i-1];
      win[0] = smp;
      ch_cnt = (ch_cnt + 1) & 16'hFFFF;
      pend = (ch_cnt - em_cnt) & 16'hFFFF;
      n = 0;
      while ((last ? pend > 0 : pend > hi) && n < 9) begin
        pending_q.push_back(window_result(pend, lo, hi, last));
        em_cnt = (em_cnt + 1) & 16'hFFFF;
        pend--;
        n++;
      end
      if (last) begin
        ch_cnt = 0;
        em_cnt = 0;
      end
    endfunction

    function void check_result(lrn_out_t got);
      lrn_out_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result %h", got.result);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.result !== want.result) begin
        $error("result: expected %h, actual %h", want.result, got.result);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_position: expected %b, actual %b", want.last, got.last);
        errors++;
      end
      if (got.sat !== want.sat) begin
        $error("saturated: expected %b, actual %b", want.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [15:0] sample_i = '0;
  logic        last_channel_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [15:0] result_o;
  logic        last_of_position_o;
  logic        saturated_o;

  lrn_scoreboard sb = new();
  bit quiet = 0;
  int sent = 0;
  int stall_left = 0;

  local_response_norm dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{result_o, last_of_position_o, saturated_o});
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall_i <= 1;
    end else begin
      out_stall_i <= 0;
    end
  end

  task automatic send_item(logic [15:0] smp, bit last);
    in_valid_i <= 1;
    sample_i <= smp;
    last_channel_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(smp, last);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after its last write
  task automatic write_reg(lrn_pkg::lrn_reg_e idx, logic [31:0] v);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic set_all(logic [31:0] sc, logic [31:0] bs, logic [15:0] ex, logic [4:0] ws);
    drain();
    write_reg(lrn_pkg::REG_SCALE, sc);
    write_reg(lrn_pkg::REG_BIAS, bs);
    write_reg(lrn_pkg::REG_EXPONENT, {16'd0, ex});
    write_reg(lrn_pkg::REG_WINDOW, {27'd0, ws});
    cfg_we_i <= 0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32(logic [31:0] lo_end);
    case ($urandom_range(0, 4))
      0: return lo_end;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 1 << 20) | lo_end;
      default: return $urandom | lo_end;
    endcase
  endfunction

  task automatic send_position(int n);
    for (int i = 0; i < n; i++) send_item(pick_sample(), i == n - 1);
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: defaults, extremes
    send_item(16'h7FFF, 0);
    send_item(16'h8000, 0);
    send_item(16'h0000, 0);
    send_item(16'h0001, 0);
    send_item(16'hFFFF, 1);
    set_all(32'd0, 32'd65536, 16'd0, 5'd3);
    send_item(16'h8000, 0);
    send_item(16'h7FFF, 0);
    send_item(16'h1234, 1);
    set_all(32'hFFFF_FFFF, 32'd1, 16'hFFFF, 5'd16);
    send_item(16'h8000, 0);
    send_item(16'h7FFF, 0);
    send_item(16'h0003, 0);
    send_item(16'h8000, 1);
    // zero-size and oversize windows
    set_all(32'h8000_0000, 32'hFFFF_FFFF, 16'd100, 5'd0);
    send_item(16'h4000, 0);
    send_item(16'hC000, 1);
    set_all(32'h0100_0000, 32'd65536, 16'd40000, 5'd20);
    send_position(3);
    // zero base
    set_all(32'd0, 32'd0, 16'd12288, 5'd1);
    send_item(16'h0000, 0);
    send_item(16'h0100, 1);
    // window change mid-position
    set_all(32'd429497, 32'd65536, 16'd12288, 5'd5);
    send_item(16'h0200, 0);
    send_item(16'hFE00, 0);
    drain();
    write_reg(lrn_pkg::REG_WINDOW, 32'd2);
    cfg_we_i <= 0;
    send_item(16'h0300, 0);
    send_item(16'h0040, 1);

    while (sent < 150) begin
      if ($urandom_range(0, 3) == 0)
        set_all(pick32(0), pick32(1), ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                ($urandom_range(0, 2) == 0) ? 5'(16 * $urandom_range(0, 1))
                                            : 5'($urandom_range(1, 16)));
      if (sent > 120) quiet = 1;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
      send_position(n);
    end
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("local_response_norm_tb: PASS");
    end else begin
      $display("local_response_norm_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("local_response_norm_tb: FAIL");
    $finish;
  end
endmodule
